// File: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and map helpers for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Map word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int ID_IN_W  = 10;
    localparam int STATUS_W = 2;
    localparam int GID_W    = 8;
    localparam int COUNT_W  = 9;

    // Parameter defaults
    localparam int DEF_NUM_BLOCKS     = 256;
    localparam int DEF_RESERVED_START = 0;
    localparam int DEF_RESERVED_COUNT = 1;
    localparam int MAX_RESERVED       = 8;

    // Operation codes on func
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Reserved bits that fall into map word widx
    function automatic word_t rsv_word(int widx, int rstart, int rcount, int nblk);
        int    b;
        word_t m;
        m = '0;
        for (int k = 0; k < MAX_RESERVED; k++)
        begin
            b = rstart + k;
            if (k < rcount && b < nblk && (b >> BIT_W) == widx)
            begin
                m[b[BIT_W-1:0]] = 1'b1;
            end
        end
        return m;
    endfunction

    // Bits of map word widx that lie past the last block
    function automatic word_t pad_word(int widx, int nblk);
        word_t m;
        m = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (widx * WORD_W + j >= nblk)
            begin
                m[j] = 1'b1;
            end
        end
        return m;
    endfunction

    // Reserved blocks that lie inside the map
    function automatic int rsv_total(int rstart, int rcount, int nblk);
        int n;
        n = 0;
        for (int k = 0; k < MAX_RESERVED; k++)
        begin
            if (k < rcount && rstart + k < nblk)
            begin
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram
// Single-port-write, single-port-read map memory, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  word_t             wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output word_t             rd_data
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/bba_ffz.sv
// ----------------------------------------------------------------------------
// bba_ffz
// Find first zero: index of the lowest clear bit of one map word.
// ----------------------------------------------------------------------------
module bba_ffz
    import bba_pkg::*;
(
    input  word_t             word,
    output logic [BIT_W-1:0]  idx
);

    always_comb
    begin
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                idx = BIT_W'(i);
            end
        end
    end

endmodule

// File: hdl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit bitmap allocator over NUM_BLOCKS blocks, map held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func and blk_num with start high; the item is
//   taken at the edge where start is high and busy is low. func 0 allocates
//   the lowest free block, 1 claims blk_num, 2 releases blk_num.
//   Result channel: done pulses for one cycle with status, granted_id,
//   used_count and free_count. The receiver cannot stall; it must take the
//   result in that cycle.
//   Sequence: the accepting edge registers the item and enters S_RD, which
//   issues the read of one map word; S_EX modifies the registered read data,
//   writes the word back and registers the result, and done rises as the
//   sequencer returns to idle. Busy drops in the done cycle, so the next item
//   can be taken while a result is shown, but not while one is in progress.
//   A per-word full bit in flops points allocate at the first word with a
//   free block; the word itself is then searched for its first clear bit.
//   Reset: the map words are seen through per-word valid bits, so an unwritten
//   word reads as its reset pattern (reserved blocks set); no clearing pass
//   is needed and an item can be taken right after reset.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS     = DEF_NUM_BLOCKS,
    parameter int RESERVED_START = DEF_RESERVED_START,
    parameter int RESERVED_COUNT = DEF_RESERVED_COUNT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [ID_IN_W-1:0]   blk_num,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [GID_W-1:0]     granted_id,
    output logic [COUNT_W-1:0]   used_count,
    output logic [COUNT_W-1:0]   free_count
);

    // Geometry
    localparam int NW      = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WIDX    = (NW > 1) ? $clog2(NW) : 1;
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int RSV_CNT = rsv_total(RESERVED_START, RESERVED_COUNT, NUM_BLOCKS);
    localparam int GA_W    = WIDX + BIT_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EX   = 2'd2;

    // Internal operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_REQ   = 2'd1;
    localparam logic [1:0] OP_REL   = 2'd2;
    localparam logic [1:0] OP_EARLY = 2'd3;   // result known at accept, no map access

    logic [1:0]          state_reg, state_next;
    logic [1:0]          op_reg;
    logic [STATUS_W-1:0] early_st_reg;
    logic [WIDX-1:0]     addr_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic [GID_W-1:0]    req_gid_reg;

    logic [NW-1:0]       valid_reg;
    logic [NW-1:0]       full_reg;
    logic [CNT_W-1:0]    used_reg, used_next;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [GID_W-1:0]    gid_reg;
    logic [CNT_W-1:0]    out_used_reg;

    // Per-word reset pattern and padding past the last block
    word_t rsv_tbl [NW];
    word_t pad_tbl [NW];

    always_comb
    begin
        for (int w = 0; w < NW; w++)
        begin
            rsv_tbl[w] = rsv_word(w, RESERVED_START, RESERVED_COUNT, NUM_BLOCKS);
            pad_tbl[w] = pad_word(w, NUM_BLOCKS);
        end
    end

    // ------------------------------------------------------------------
    // Accept-time decode
    // ------------------------------------------------------------------
    logic                accept;
    logic                in_range;
    logic [WIDX-1:0]     free_word;
    logic                any_free;
    logic [1:0]          op_in;
    logic [STATUS_W-1:0] early_st_in;
    logic [WIDX-1:0]     addr_in;

    assign accept   = start && !busy;
    assign in_range = {1'b0, blk_num} < (ID_IN_W + 1)'(NUM_BLOCKS);
    assign any_free = !(&full_reg);

    // Lowest word that still holds a free block
    always_comb
    begin
        free_word = '0;
        for (int w = NW - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                free_word = WIDX'(w);
            end
        end
    end

    always_comb
    begin
        op_in       = OP_EARLY;
        early_st_in = ST_OK;
        addr_in     = blk_num[BIT_W +: WIDX];
        case (func)
            FN_ALLOC:
            begin
                addr_in = free_word;
                if (any_free)
                begin
                    op_in = OP_ALLOC;
                end
                else
                begin
                    early_st_in = ST_FULL;
                end
            end
            FN_REQUEST:
            begin
                if (in_range)
                begin
                    op_in = OP_REQ;
                end
                else
                begin
                    early_st_in = ST_RANGE;
                end
            end
            FN_RELEASE:
            begin
                if (in_range)
                begin
                    op_in = OP_REL;
                end
                else
                begin
                    early_st_in = ST_RANGE;
                end
            end
            default:
            begin
                op_in = OP_EARLY;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Map memory and word search
    // ------------------------------------------------------------------
    word_t            rd_data;
    word_t            base;
    word_t            view;
    word_t            new_word;
    logic [BIT_W-1:0] fz_idx;
    logic             wr_en;

    bba_map_ram #(
        .DEPTH  (NW),
        .ADDR_W (WIDX)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (new_word),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign base = valid_reg[addr_reg] ? rd_data : rsv_tbl[addr_reg];
    assign view = base | pad_tbl[addr_reg];

    bba_ffz u_ffz (
        .word (view),
        .idx  (fz_idx)
    );

    // ------------------------------------------------------------------
    // Modify step
    // ------------------------------------------------------------------
    logic                do_write;
    logic [STATUS_W-1:0] res_status;
    logic [GID_W-1:0]    res_gid;
    logic [GA_W+GID_W-1:0] alloc_gid_ext;

    assign alloc_gid_ext = (GA_W + GID_W)'({addr_reg, fz_idx});

    always_comb
    begin
        do_write   = 1'b0;
        new_word   = base;
        res_status = ST_OK;
        res_gid    = '0;
        used_next  = used_reg;
        case (op_reg)
            OP_ALLOC:
            begin
                do_write         = 1'b1;
                new_word[fz_idx] = 1'b1;
                res_gid          = alloc_gid_ext[GID_W-1:0];
                used_next        = used_reg + CNT_W'(1);
            end
            OP_REQ:
            begin
                if (base[bit_reg])
                begin
                    res_status = ST_TAKEN;
                end
                else
                begin
                    do_write          = 1'b1;
                    new_word[bit_reg] = 1'b1;
                    res_gid           = req_gid_reg;
                    used_next         = used_reg + CNT_W'(1);
                end
            end
            OP_REL:
            begin
                do_write          = 1'b1;
                new_word[bit_reg] = 1'b0;
                if (base[bit_reg])
                begin
                    used_next = used_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_status = early_st_reg;
            end
        endcase
    end

    assign wr_en = (state_reg == S_EX) && do_write;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            used_reg  <= CNT_W'(RSV_CNT);
            done_reg  <= 1'b0;
            for (int w = 0; w < NW; w++)
            begin
                full_reg[w] <= &(rsv_word(w, RESERVED_START, RESERVED_COUNT, NUM_BLOCKS)
                                 | pad_word(w, NUM_BLOCKS));
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EX);
            if (state_reg == S_EX)
            begin
                used_reg <= used_next;
                if (do_write)
                begin
                    valid_reg[addr_reg] <= 1'b1;
                    full_reg[addr_reg]  <= &(new_word | pad_tbl[addr_reg]);
                end
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_in;
            early_st_reg <= early_st_in;
            addr_reg     <= addr_in;
            bit_reg      <= blk_num[BIT_W-1:0];
            req_gid_reg  <= blk_num[GID_W-1:0];
        end
        if (state_reg == S_EX)
        begin
            status_reg   <= res_status;
            gid_reg      <= res_gid;
            out_used_reg <= used_next;
        end
    end

    // ------------------------------------------------------------------
    // Result ports; counts wrap to the field width
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]         free_cnt;
    logic [CNT_W+COUNT_W-1:0] used_ext;
    logic [CNT_W+COUNT_W-1:0] free_ext;

    assign free_cnt   = CNT_W'(NUM_BLOCKS) - out_used_reg;
    assign used_ext   = (CNT_W + COUNT_W)'(out_used_reg);
    assign free_ext   = (CNT_W + COUNT_W)'(free_cnt);

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = gid_reg;
    assign used_count = used_ext[COUNT_W-1:0];
    assign free_count = free_ext[COUNT_W-1:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_ex: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EX))
        else $error("result strobe without modify step");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted item");

    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (&full_reg) == (used_reg == CNT_W'(NUM_BLOCKS)))
        else $error("word full bits disagree with used count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NUM_BLOCKS))
        else $error("used count exceeds block count");

endmodule
